/* sv/tss_pkg.sv */
// shared types and constants for the tick scheduler
`default_nettype none
package tss_pkg;
   localparam logic [2:0] OP_SCHEDULE = 3'd0;
   localparam logic [2:0] OP_SLEEP    = 3'd1;
   localparam logic [2:0] OP_P        = 3'd2;
   localparam logic [2:0] OP_V        = 3'd3;
   localparam logic [2:0] OP_SET_TASK = 3'd4;
   localparam logic [2:0] OP_SET_SEM  = 3'd5;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  task_index;
      logic [2:0]  sem_index;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]        current_task;
      logic              none_ready;
      logic              blocked;
      logic              woken_valid;
      logic [2:0]        woken_task;
      logic signed [7:0] sem_count;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture request, do the opcode work
      logic sleep_dec; // decrement sleep counts
      logic scan_clr;  // start a pick scan
      logic scan_step; // examine one task
      logic refill;    // refill ticks of one task (scan index)
      logic commit;    // take the pick result
      logic mark_none; // flag none ready
      logic show;      // load the response register
   } cmd_type;

   typedef struct packed {
      logic need_sched; // captured opcode calls for a schedule
      logic scan_last;  // scan index at last task
      logic found;      // pick found nonzero ticks
   } sts_type;
endpackage
`default_nettype wire

/* sv/tick_scheduler_with_semaphores.sv */
// top level of the tick scheduler with counting semaphores
// channel   | direction | ports
// request   | in        | req_valid, req_stall, req_data
// response  | out       | rsp_valid, rsp_stall, rsp_data
// sequence: requests with no schedule pass S_DEC to S_OUT; a schedule runs a first
// scan, commits if it finds ticks, else runs a refill pass and a second scan;
// the scan examines one task per cycle
// reset: synchronous, clears task table, semaphores and queue lengths
// stalls: request port stalls while a request is in flight; a held response
// holds the next request at its result stage
`default_nettype none
module tick_scheduler_with_semaphores #(
   parameter int NUM_TASKS      = 8,
   parameter int NUM_SEMAPHORES = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  tss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output tss_pkg::rsp_type rsp_data
);
   tss_pkg::cmd_type cmd;
   tss_pkg::sts_type sts;

   // sequencer
   tss_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   // tables and scan
   tss_dp #(.NUM_TASKS(NUM_TASKS), .NUM_SEMAPHORES(NUM_SEMAPHORES)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .sts(sts), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

/* sv/tss_ctrl.sv */
// scheduler sequencer
`default_nettype none
module tss_ctrl (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire             rsp_stall,
   input  tss_pkg::sts_type sts,
   output tss_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_DEC, S_PICK1, S_REFILL, S_PICK2, S_OUT
   } state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.need_sched) begin
               cmd.sleep_dec = 1'b1;
               cmd.scan_clr  = 1'b1;
               state_in      = S_PICK1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_PICK1: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_REFILL;
         end
         S_REFILL: begin
            if (sts.found) begin
               cmd.commit = 1'b1;
               state_in   = S_OUT;
            end else begin
               cmd.refill    = 1'b1;
               cmd.scan_step = 1'b1;
               if (sts.scan_last) state_in = S_PICK2;
            end
         end
         S_PICK2: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_OUT;
         end
         S_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (sts.need_sched) begin
                  cmd.commit    = sts.found;
                  cmd.mark_none = !sts.found;
               end
               cmd.show     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accept while busy");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && state_in == S_IDLE) |=> rsp_valid)
      else $error("result not shown");
endmodule
`default_nettype wire

/* sv/tss_dp.sv */
// task table, semaphores, wait queues and pick scan
`default_nettype none
module tss_dp #(
   parameter int NUM_TASKS      = 8,
   parameter int NUM_SEMAPHORES = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  tss_pkg::req_type  req_data,
   input  tss_pkg::cmd_type  cmd,
   output tss_pkg::sts_type  sts,
   output tss_pkg::rsp_type  rsp_data
);
   localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int LW = $clog2(NUM_TASKS + 1);
   localparam int QD = NUM_SEMAPHORES << TW;
   localparam int QW = $clog2(QD);

   logic [15:0] ticks_ff [NUM_TASKS];
   logic [15:0] prio_ff  [NUM_TASKS];
   logic [15:0] sleep_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0] wait_ff;
   logic [TW-1:0] run_ff;
   logic signed [7:0] cnt_ff [NUM_SEMAPHORES];
   logic [LW-1:0] len_ff  [NUM_SEMAPHORES];
   logic [TW-1:0] hptr_ff [NUM_SEMAPHORES];
   logic [TW-1:0] queue_mem [QD];
   logic [TW-1:0] head_rd_ff;

   logic [TW-1:0] scan_ff;
   logic [15:0]   best_ff;
   logic [TW-1:0] who_ff;
   logic          sched_ff;
   logic          wake_ff;
   tss_pkg::rsp_type out_ff;
   tss_pkg::rsp_type rsp_ff, rsp_in;

   logic sem_ok, elig;
   logic [SW-1:0] si;
   logic [TW-1:0] ti;
   logic signed [8:0] cm, cp;
   logic [TW:0]   tsum;
   logic [TW-1:0] tailp;

   assign si = SW'(req_data.sem_index);
   assign ti = TW'(req_data.task_index);
   assign sem_ok = {29'd0, req_data.sem_index} < 32'(NUM_SEMAPHORES);
   assign elig = !wait_ff[scan_ff] && sleep_ff[scan_ff] == 16'd0;
   assign cm = 9'(cnt_ff[si]) - 9'sd1;
   assign cp = 9'(cnt_ff[si]) + 9'sd1;
   // tail slot of the circular queue, wrapped by one compare and subtract
   assign tsum  = {1'b0, hptr_ff[si]} + (TW+1)'(len_ff[si]);
   assign tailp = (tsum >= (TW+1)'(NUM_TASKS)) ? TW'(tsum - (TW+1)'(NUM_TASKS))
                                               : tsum[TW-1:0];

   assign sts.need_sched = sched_ff;
   assign sts.scan_last  = scan_ff == TW'(NUM_TASKS - 1);
   assign sts.found      = best_ff != 16'd0;
   assign rsp_data       = rsp_ff;

   // response snapshot, taken with the pick result of this request
   always_comb begin
      rsp_in              = out_ff;
      rsp_in.current_task = 3'(cmd.commit ? who_ff : run_ff);
      rsp_in.none_ready   = cmd.mark_none;
   end

   // head entry read, registered; available on the cycle after a V is accepted
   always_ff @(posedge clock) begin
      head_rd_ff <= queue_mem[QW'({si, hptr_ff[si]})];
      if (cmd.load && req_data.opcode == tss_pkg::OP_P && sem_ok && cm < 0 &&
          32'(len_ff[si]) < NUM_TASKS)
         queue_mem[QW'({si, tailp})] <= run_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TASKS; t++) begin
            ticks_ff[t] <= '0; prio_ff[t] <= '0; sleep_ff[t] <= '0;
         end
         for (int s = 0; s < NUM_SEMAPHORES; s++) begin
            cnt_ff[s] <= '0; len_ff[s] <= '0; hptr_ff[s] <= '0;
         end
         wait_ff  <= '0;
         run_ff   <= '0;
         sched_ff <= 1'b0;
         wake_ff  <= 1'b0;
         scan_ff  <= '0;
         best_ff  <= '0;
         who_ff   <= '0;
         out_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         wake_ff <= cmd.load && req_data.opcode == tss_pkg::OP_V && sem_ok &&
                    cp <= 0 && len_ff[si] != '0;
         if (cmd.load) begin
            sched_ff <= 1'b0;
            out_ff   <= '0;
            case (req_data.opcode)
               tss_pkg::OP_SCHEDULE: sched_ff <= 1'b1;
               tss_pkg::OP_SLEEP: begin
                  sleep_ff[run_ff] <= req_data.value;
                  sched_ff <= 1'b1;
               end
               tss_pkg::OP_P: if (sem_ok) begin
                  if (cm >= 0) begin
                     cnt_ff[si] <= 8'(cm);
                     out_ff.sem_count <= 8'(cm);
                  end else if (32'(len_ff[si]) < NUM_TASKS) begin
                     cnt_ff[si] <= (cm < -9'sd128) ? -8'sd128 : 8'(cm);
                     out_ff.sem_count <= (cm < -9'sd128) ? -8'sd128 : 8'(cm);
                     wait_ff[run_ff] <= 1'b1;
                     len_ff[si] <= len_ff[si] + 1'b1;
                     out_ff.blocked <= 1'b1;
                     sched_ff <= 1'b1;
                  end else begin
                     out_ff.sem_count <= cnt_ff[si];
                  end
               end
               tss_pkg::OP_V: if (sem_ok) begin
                  cnt_ff[si] <= (cp > 9'sd127) ? 8'sd127 : 8'(cp);
                  out_ff.sem_count <= (cp > 9'sd127) ? 8'sd127 : 8'(cp);
                  if (cp <= 0 && len_ff[si] != '0) begin
                     len_ff[si] <= len_ff[si] - 1'b1;
                     hptr_ff[si] <= (hptr_ff[si] == TW'(NUM_TASKS - 1)) ? '0
                                    : hptr_ff[si] + 1'b1;
                     out_ff.woken_valid <= 1'b1;
                  end
               end
               tss_pkg::OP_SET_TASK:
                  if ({29'd0, req_data.task_index} < 32'(NUM_TASKS)) begin
                     prio_ff[ti]  <= req_data.value;
                     ticks_ff[ti] <= req_data.value;
                  end
               tss_pkg::OP_SET_SEM: if (sem_ok) begin
                  cnt_ff[si] <= (req_data.value > 16'd127) ? 8'sd127
                                : 8'(req_data.value);
                  out_ff.sem_count <= (req_data.value > 16'd127) ? 8'sd127
                                : 8'(req_data.value);
               end
               default: ;
            endcase
         end
         // wake the head in the cycle after the V load, from registered read
         if (wake_ff) begin
            wait_ff[head_rd_ff] <= 1'b0;
            out_ff.woken_task <= 3'(head_rd_ff);
         end
         if (cmd.sleep_dec)
            for (int t = 0; t < NUM_TASKS; t++)
               if (sleep_ff[t] != '0) sleep_ff[t] <= sleep_ff[t] - 1'b1;
         if (cmd.scan_clr) begin
            scan_ff <= '0;
            best_ff <= '0;
            who_ff  <= '0;
         end else if (cmd.scan_step) begin
            scan_ff <= sts.scan_last ? '0 : scan_ff + 1'b1;
            if (cmd.refill) begin
               if (elig) ticks_ff[scan_ff] <= prio_ff[scan_ff];
            end else if (elig && ticks_ff[scan_ff] > best_ff) begin
               best_ff <= ticks_ff[scan_ff];
               who_ff  <= scan_ff;
            end
         end
         if (cmd.commit) run_ff <= who_ff;
         if (cmd.show) rsp_ff <= rsp_in;
      end
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff[si]) <= NUM_TASKS) else $error("queue overrun");
   a_refill_nofound: assert property (@(posedge clock) disable iff (reset)
      cmd.refill |-> !sts.found) else $error("refill after pick");
   a_commit_nz: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> best_ff != 16'd0) else $error("commit of zero ticks");
endmodule
`default_nettype wire
